### design/hsv2rgb_pkg.sv
// hsv2rgb_pkg: shared constants, word types and the divide-by-full-scale helper
// for the hsv to rgb converter. No dependencies.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    // colour and hue number formats
    localparam int COLOR_BITS    = 8;
    localparam int HUE_FRAC_BITS = 6;
    localparam int HUE_W         = 15;
    localparam int SECTOR_DEG    = 60;

    // derived sizes
    localparam int COLOR_FULL  = (1 << COLOR_BITS) - 1;
    localparam int SECTOR_SPAN = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int REM_W       = $clog2(SECTOR_SPAN + 1);
    localparam int SECTOR_MAX  = ((1 << HUE_W) - 1) / SECTOR_SPAN;
    localparam int SECTOR_W    = $clog2(SECTOR_MAX + 1);
    localparam int DEN         = COLOR_FULL * SECTOR_SPAN;
    localparam int DEN_W       = $clog2(DEN + 1);
    localparam int PROD_W      = 2 * COLOR_BITS;
    localparam int X_W         = COLOR_BITS + DEN_W;

    // 60 degrees = 15 * 4 * 2^frac, so the span splits into a shift and a divide by 15
    localparam int SPAN_SHIFT  = HUE_FRAC_BITS + 2;
    localparam int Y_W         = X_W - SPAN_SHIFT;
    localparam int DIV15       = 15;
    localparam int RECIP15     = 4369;   // 0x1111, just under 2^16 / 15
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 32;

    // input word
    typedef struct packed {
        logic [HUE_W-1:0]      hue;
        logic [COLOR_BITS-1:0] saturation;
        logic [COLOR_BITS-1:0] brightness;
    } hsv_word_t;

    // result word
    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } rgb_word_t;

    // exact floor(x / full scale): estimate low by at most one, then one correction
    function automatic logic [COLOR_BITS-1:0] div_full(input logic [PROD_W-1:0] x);
        logic [PROD_W:0]     a;
        logic [COLOR_BITS:0] q0;
        logic [PROD_W:0]     r;
        a  = {1'b0, x} + (PROD_W + 1)'(x >> COLOR_BITS);
        q0 = a[PROD_W:COLOR_BITS];
        r  = {1'b0, x} - ((PROD_W + 1)'(q0) << COLOR_BITS) + (PROD_W + 1)'(q0);
        if (r >= (PROD_W + 1)'(COLOR_FULL)) begin
            q0 = q0 + 1'b1;
        end
        return q0[COLOR_BITS-1:0];
    endfunction

endpackage

### design/hsv_to_rgb_converter_top.sv
// hsv_to_rgb_converter_top: seven-stage pipelined hsv to rgb pixel converter
// depends on hsv2rgb_pkg for word types, sizes and the divide helper
`timescale 1ns / 1ps

// Usage
//   s_valid/s_ready/s_data carry one hsv word per handshake: hue in degrees
//   with 6 fraction bits, saturation and brightness as 8-bit fractions
//   (255 is 1.0). m_valid/m_ready/m_data carry the rgb word, 8 bits a colour.
//   With m_ready held high, the edge that accepts the word loads the first
//   of seven register stages; m_valid rises when the word reaches the last.
//   Throughput is one word per cycle while m_ready stays high; the stages,
//   in order, are:
//   sector split, p/q/t weights, brightness products, divide-by-15 estimate,
//   its correction, divide by full scale, sector select into the output reg.
//   Each stage carries its own valid bit and loads whenever it is empty or
//   the stage after it moves, so bubbles close up and a word held at the
//   output does not stop earlier stages from filling.
//   When the receiver stalls the output word holds; s_ready drops only once
//   every stage holds a word. Nothing is lost or repeated.
//   Reset (aresetn low, synchronous) empties the pipeline; there is no other
//   state, and zero saturation falls out of the arithmetic as grey.

module hsv_to_rgb_converter_top
    import hsv2rgb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  hsv_word_t s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output rgb_word_t m_data
);

    localparam int NSTAGE = 7;

    // sector codes
    localparam logic [SECTOR_W-1:0] SECT_0 = SECTOR_W'(0);
    localparam logic [SECTOR_W-1:0] SECT_1 = SECTOR_W'(1);
    localparam logic [SECTOR_W-1:0] SECT_2 = SECTOR_W'(2);
    localparam logic [SECTOR_W-1:0] SECT_3 = SECTOR_W'(3);
    localparam logic [SECTOR_W-1:0] SECT_4 = SECTOR_W'(4);

    typedef struct packed {
        logic [SECTOR_W-1:0]   sector;
        logic [REM_W-1:0]      rem;
        logic [REM_W-1:0]      remc;
        logic [COLOR_BITS-1:0] s;
        logic [COLOR_BITS-1:0] v;
    } st1_t;

    typedef struct packed {
        logic [SECTOR_W-1:0]   sector;
        logic [DEN_W-1:0]      wq;
        logic [DEN_W-1:0]      wt;
        logic [PROD_W-1:0]     pv;
        logic [COLOR_BITS-1:0] v;
    } st2_t;

    typedef struct packed {
        logic [SECTOR_W-1:0]   sector;
        logic [X_W-1:0]        xq;
        logic [X_W-1:0]        xt;
        logic [COLOR_BITS-1:0] p;
        logic [COLOR_BITS-1:0] v;
    } st3_t;

    typedef struct packed {
        logic [SECTOR_W-1:0]   sector;
        logic [Y_W-1:0]        yq;
        logic [Y_W-1:0]        yt;
        logic [RECIP_W-1:0]    mq;
        logic [RECIP_W-1:0]    mt;
        logic [COLOR_BITS-1:0] p;
        logic [COLOR_BITS-1:0] v;
    } st4_t;

    typedef struct packed {
        logic [SECTOR_W-1:0]   sector;
        logic [PROD_W-1:0]     zq;
        logic [PROD_W-1:0]     zt;
        logic [COLOR_BITS-1:0] p;
        logic [COLOR_BITS-1:0] v;
    } st5_t;

    typedef struct packed {
        logic [SECTOR_W-1:0]   sector;
        logic [COLOR_BITS-1:0] q;
        logic [COLOR_BITS-1:0] t;
        logic [COLOR_BITS-1:0] p;
        logic [COLOR_BITS-1:0] v;
    } st6_t;

    logic [NSTAGE:1] vld_reg;
    logic [NSTAGE:1] load;

    st1_t      st1_reg, st1_next;
    st2_t      st2_reg, st2_next;
    st3_t      st3_reg, st3_next;
    st4_t      st4_reg, st4_next;
    st5_t      st5_reg, st5_next;
    st6_t      st6_reg, st6_next;
    rgb_word_t out_reg, out_next;

    // load enables: a stage moves when empty or when the next one moves
    always_comb begin
        load[NSTAGE] = !vld_reg[NSTAGE] || m_ready;
        for (int i = NSTAGE - 1; i >= 1; i--) begin
            load[i] = !vld_reg[i] || load[i+1];
        end
    end

    assign s_ready = load[1];
    assign m_valid = vld_reg[NSTAGE];
    assign m_data  = out_reg;

    // stage 1: split hue into sector and remainder by constant compares
    always_comb begin
        logic [HUE_W-1:0] base;
        logic [HUE_W-1:0] rem_full;
        st1_next.sector = '0;
        base            = '0;
        for (int k = 1; k <= SECTOR_MAX; k++) begin
            if (s_data.hue >= HUE_W'(k * SECTOR_SPAN)) begin
                st1_next.sector = SECTOR_W'(k);
                base            = HUE_W'(k * SECTOR_SPAN);
            end
        end
        rem_full      = s_data.hue - base;
        st1_next.rem  = rem_full[REM_W-1:0];
        st1_next.remc = REM_W'(SECTOR_SPAN) - rem_full[REM_W-1:0];
        st1_next.s    = s_data.saturation;
        st1_next.v    = s_data.brightness;
    end

    // stage 2: saturation weights for q and t, brightness product for p
    always_comb begin
        logic [DEN_W-1:0] sr;
        logic [DEN_W-1:0] sdr;
        sr              = DEN_W'(st1_reg.s) * DEN_W'(st1_reg.rem);
        sdr             = DEN_W'(st1_reg.s) * DEN_W'(st1_reg.remc);
        st2_next.wq     = DEN_W'(DEN) - sr;
        st2_next.wt     = DEN_W'(DEN) - sdr;
        st2_next.pv     = PROD_W'(st1_reg.v) * PROD_W'(COLOR_FULL - int'(st1_reg.s));
        st2_next.sector = st1_reg.sector;
        st2_next.v      = st1_reg.v;
    end

    // stage 3: brightness times weights, p finished by divide by full scale
    always_comb begin
        st3_next.xq     = X_W'(st2_reg.v) * X_W'(st2_reg.wq);
        st3_next.xt     = X_W'(st2_reg.v) * X_W'(st2_reg.wt);
        st3_next.p      = div_full(st2_reg.pv);
        st3_next.sector = st2_reg.sector;
        st3_next.v      = st2_reg.v;
    end

    // stage 4: drop the power-of-two part of the span, reciprocal multiply by 1/15
    always_comb begin
        st4_next.yq     = st3_reg.xq[X_W-1:SPAN_SHIFT];
        st4_next.yt     = st3_reg.xt[X_W-1:SPAN_SHIFT];
        st4_next.mq     = RECIP_W'(st3_reg.xq[X_W-1:SPAN_SHIFT]) * RECIP_W'(RECIP15);
        st4_next.mt     = RECIP_W'(st3_reg.xt[X_W-1:SPAN_SHIFT]) * RECIP_W'(RECIP15);
        st4_next.sector = st3_reg.sector;
        st4_next.p      = st3_reg.p;
        st4_next.v      = st3_reg.v;
    end

    // stage 5: divide-by-15 correction, the estimate is low by at most one
    always_comb begin
        logic [PROD_W-1:0] eq;
        logic [PROD_W-1:0] et;
        logic [Y_W-1:0]    rq;
        logic [Y_W-1:0]    rt;
        eq = st4_reg.mq[RECIP_SHIFT +: PROD_W];
        et = st4_reg.mt[RECIP_SHIFT +: PROD_W];
        rq = st4_reg.yq - Y_W'(eq) * Y_W'(DIV15);
        rt = st4_reg.yt - Y_W'(et) * Y_W'(DIV15);
        st5_next.zq     = (rq >= Y_W'(DIV15)) ? eq + 1'b1 : eq;
        st5_next.zt     = (rt >= Y_W'(DIV15)) ? et + 1'b1 : et;
        st5_next.sector = st4_reg.sector;
        st5_next.p      = st4_reg.p;
        st5_next.v      = st4_reg.v;
    end

    // stage 6: q and t finished by divide by full scale
    always_comb begin
        st6_next.q      = div_full(st5_reg.zq);
        st6_next.t      = div_full(st5_reg.zt);
        st6_next.sector = st5_reg.sector;
        st6_next.p      = st5_reg.p;
        st6_next.v      = st5_reg.v;
    end

    // stage 7: per-sector selection into the output word
    always_comb begin
        case (st6_reg.sector)
            SECT_0:  out_next = '{red: st6_reg.v, green: st6_reg.t, blue: st6_reg.p};
            SECT_1:  out_next = '{red: st6_reg.q, green: st6_reg.v, blue: st6_reg.p};
            SECT_2:  out_next = '{red: st6_reg.p, green: st6_reg.v, blue: st6_reg.t};
            SECT_3:  out_next = '{red: st6_reg.p, green: st6_reg.q, blue: st6_reg.v};
            SECT_4:  out_next = '{red: st6_reg.t, green: st6_reg.p, blue: st6_reg.v};
            default: out_next = '{red: st6_reg.v, green: st6_reg.p, blue: st6_reg.q};
        endcase
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = NSTAGE; i >= 2; i--) begin
                if (load[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            if (load[1]) begin
                vld_reg[1] <= s_valid;
            end
        end
    end

    // stage data registers
    always_ff @(posedge aclk) begin
        if (load[1]) begin
            st1_reg <= st1_next;
        end
        if (load[2]) begin
            st2_reg <= st2_next;
        end
        if (load[3]) begin
            st3_reg <= st3_next;
        end
        if (load[4]) begin
            st4_reg <= st4_next;
        end
        if (load[5]) begin
            st5_reg <= st5_next;
        end
        if (load[6]) begin
            st6_reg <= st6_next;
        end
        if (load[7]) begin
            out_reg <= out_next;
        end
    end

    // an empty output stage means the whole pipeline can move
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low while the output stage is empty");

    // remainder stays inside one sector
    a_rem_in_sector: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[1] |-> (st1_reg.rem < REM_W'(SECTOR_SPAN)))
        else $error("hue remainder outside its sector");

    // p, q and t never exceed brightness
    a_pqt_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[6] |-> (st6_reg.p <= st6_reg.v && st6_reg.q <= st6_reg.v &&
                        st6_reg.t <= st6_reg.v))
        else $error("p, q or t above brightness");

    // a word leaving stage 6 arrives at the output
    a_stage6_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[6] && load[7]) |=> m_valid)
        else $error("word lost between stage 6 and the output register");

    // a stalled output word keeps the pipeline behind it from overwriting it
    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_reg)))
        else $error("output register changed while stalled");

endmodule

### bench/hsv_to_rgb_converter_checker.sv
// hsv_to_rgb_converter_checker: watches both channels of the hsv to rgb converter,
// predicts each rgb word from the accepted hsv word and compares them in order
// depends on hsv2rgb_pkg for the word types and number formats
`timescale 1ns / 1ps

module hsv_to_rgb_converter_checker
    import hsv2rgb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  hsv_word_t s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  rgb_word_t m_data,
    output int        mismatch_count,
    output int        words_in_flight
);

    localparam int REPORT_MAX = 30;

    rgb_word_t rgb_expected_q[$];
    int        fails    = 0;
    int        reported = 0;

    // exact p/q/t weights, truncated, then picked by hue sector
    function automatic rgb_word_t rgb_from_hsv(input hsv_word_t px);
        longint unsigned val, sat, hue, span, full, den, sect, offs, p, q, t;
        rgb_word_t       c;
        val  = px.brightness;
        sat  = px.saturation;
        hue  = px.hue;
        span = SECTOR_SPAN;
        full = COLOR_FULL;
        den  = full * span;
        if (sat == 0) begin
            // grey
            c = {COLOR_BITS'(val), COLOR_BITS'(val), COLOR_BITS'(val)};
        end else begin
            sect = hue / span;
            offs = hue - sect * span;
            p    = (val * (full - sat)) / full;
            q    = (val * (den - sat * offs)) / den;
            t    = (val * (den - sat * (span - offs))) / den;
            case (sect)
                0: c = {COLOR_BITS'(val), COLOR_BITS'(t), COLOR_BITS'(p)};
                1: c = {COLOR_BITS'(q), COLOR_BITS'(val), COLOR_BITS'(p)};
                2: c = {COLOR_BITS'(p), COLOR_BITS'(val), COLOR_BITS'(t)};
                3: c = {COLOR_BITS'(p), COLOR_BITS'(q), COLOR_BITS'(val)};
                4: c = {COLOR_BITS'(t), COLOR_BITS'(p), COLOR_BITS'(val)};
                // sector 5 and the wrapped sectors above 360 degrees
                default: c = {COLOR_BITS'(val), COLOR_BITS'(p), COLOR_BITS'(q)};
            endcase
        end
        return c;
    endfunction

    task automatic report_field(input string name, input logic [COLOR_BITS-1:0] want,
                                input logic [COLOR_BITS-1:0] got);
        fails++;
        if (reported < REPORT_MAX) begin
            reported++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // predict on input handshake, compare on output handshake
    always @(posedge aclk) begin
        rgb_word_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                rgb_expected_q.push_back(rgb_from_hsv(s_data));
            end
            if (m_valid && m_ready) begin
                if (rgb_expected_q.size() == 0) begin
                    fails++;
                    if (reported < REPORT_MAX) begin
                        reported++;
                        $display("%0t: unexpected word, expected none, got %0d/%0d/%0d",
                                 $time, m_data.red, m_data.green, m_data.blue);
                    end
                end else begin
                    want = rgb_expected_q.pop_front();
                    if (m_data.red !== want.red) begin
                        report_field("red", want.red, m_data.red);
                    end
                    if (m_data.green !== want.green) begin
                        report_field("green", want.green, m_data.green);
                    end
                    if (m_data.blue !== want.blue) begin
                        report_field("blue", want.blue, m_data.blue);
                    end
                end
            end
        end
        words_in_flight <= rgb_expected_q.size();
        mismatch_count  <= fails;
    end

endmodule

### bench/hsv_to_rgb_converter_top_tb.sv
// hsv_to_rgb_converter_top_tb: drives hsv words into the converter with random
// idling on both sides and gives the verdict; checking sits in the checker module
// depends on hsv2rgb_pkg, hsv_to_rgb_converter_top and hsv_to_rgb_converter_checker
`timescale 1ns / 1ps

module hsv_to_rgb_converter_top_tb;
    import hsv2rgb_pkg::*;

    localparam int RANDOM_WORDS = 460;
    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int HUE_TOP      = (1 << HUE_W) - 1;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    hsv_word_t s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rgb_word_t m_data;

    int mismatch_count;
    int words_in_flight;
    int tx_idle_pct = 38;
    int rx_idle_pct = 67;
    bit rx_hold_req = 1'b0;
    bit rx_hold_done = 1'b0;
    int quiet_cycles = 0;

    hsv_to_rgb_converter_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    hsv_to_rgb_converter_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .words_in_flight (words_in_flight)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: random stalls, or one long hold-off when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req && !rx_hold_done) begin
                rx_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // offer one word, idling first at random, and wait for it to be taken
    task automatic send_word(input hsv_word_t w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_hsv(input int hue, input int sat, input int val);
        hsv_word_t w;
        w.hue        = HUE_W'(hue);
        w.saturation = COLOR_BITS'(sat);
        w.brightness = COLOR_BITS'(val);
        send_word(w);
    endtask

    // saturation and brightness lean on 0, 1 and full scale
    function automatic logic [COLOR_BITS-1:0] random_fraction();
        case ($urandom_range(9))
            0:       return '0;
            1:       return COLOR_BITS'(COLOR_FULL);
            2:       return COLOR_BITS'(1);
            default: return COLOR_BITS'($urandom_range(COLOR_FULL));
        endcase
    endfunction

    // hue mostly in range, some wrapped past 360 degrees, some on sector edges
    function automatic hsv_word_t random_hsv();
        hsv_word_t w;
        int        edge_hue;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: w.hue = HUE_W'($urandom_range(SECTOR_SPAN * 6 - 1));
            7:                   w.hue = HUE_W'($urandom_range(HUE_TOP, SECTOR_SPAN * 6));
            8: begin
                edge_hue = $urandom_range(SECTOR_MAX) * SECTOR_SPAN;
                case ($urandom_range(2))
                    0:       edge_hue = edge_hue;
                    1:       edge_hue = edge_hue + 1;
                    default: edge_hue = edge_hue + SECTOR_SPAN - 1;
                endcase
                w.hue = HUE_W'((edge_hue > HUE_TOP) ? HUE_TOP : edge_hue);
            end
            default:             w.hue = HUE_W'($urandom_range(HUE_TOP));
        endcase
        w.saturation = random_fraction();
        w.brightness = random_fraction();
        return w;
    endfunction

    // stimulus and verdict
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // field extremes, grey, and the first word of every sector
        send_hsv(0, 0, 0);
        send_hsv(HUE_TOP, COLOR_FULL, COLOR_FULL);
        send_hsv(5000, 0, 200);
        send_hsv(SECTOR_SPAN * 6 - 1, 0, COLOR_FULL);
        for (int k = 0; k <= SECTOR_MAX; k++) begin
            send_hsv(k * SECTOR_SPAN, COLOR_FULL, COLOR_FULL);
        end
        send_hsv(SECTOR_SPAN - 1, COLOR_FULL, COLOR_FULL);
        send_hsv(SECTOR_SPAN * 6 - 1, 200, 180);
        send_hsv(12345, COLOR_FULL, 0);
        send_hsv(9000, 1, COLOR_FULL);
        send_hsv(SECTOR_SPAN / 2, 128, 128);
        send_hsv(SECTOR_SPAN * 7 + 17, 90, 240);

        // sender idles more lightly than receiver
        repeat (RANDOM_WORDS) send_word(random_hsv());

        // and the other way round
        tx_idle_pct = 67;
        rx_idle_pct = 38;
        repeat (RANDOM_WORDS) send_word(random_hsv());

        // full rate, opening with a long receiver hold-off so the pipe backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
        repeat (RANDOM_WORDS) send_word(random_hsv());
        s_valid <= 1'b0;

        @(posedge aclk);
        while (words_in_flight != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
